// ===== rtl/dtfp_pkg.sv =====
package dtfp_pkg;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_EMPTY     = 3'd1,
		ST_BADCHAR   = 3'd2,
		ST_TWOPOINTS = 3'd3,
		ST_EDGEPOINT = 3'd4,
		ST_NOINT     = 3'd5,
		ST_OVERFLOW  = 3'd6
	} status_t;

	localparam int VALUE_W = 64;
	localparam int TEN = 10;
	localparam int TEN_POW_N = 10;

	localparam logic [7:0] CHAR_NUL   = 8'h00;
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_NINE  = 8'h39;
	localparam logic [7:0] CHAR_MINUS = 8'h2d;
	localparam logic [7:0] CHAR_DOT   = 8'h2e;
	localparam logic [7:0] CHAR_COMMA = 8'h2c;

	localparam logic [63:0] TEN_POW [TEN_POW_N] = '{
		64'd10, 64'd100, 64'd1000, 64'd10000, 64'd100000,
		64'd1000000, 64'd10000000, 64'd100000000, 64'd1000000000,
		64'd10000000000
	};

	typedef struct packed {
		logic [7:0] char_code;
		logic       last_char;
	} char_item_t;

	typedef struct packed {
		logic signed [VALUE_W-1:0] value;
		status_t                   status;
	} result_t;

	// finished number handed from the character stage to the output stage
	typedef struct packed {
		logic [VALUE_W-1:0] mag;
		logic               neg;
		status_t            status;
	} fin_t;

endpackage

// ===== rtl/dtfp_step.sv =====
module dtfp_step #(
	parameter int FRAC_BITS   = 32,
	parameter int INT_BITS    = 31,
	parameter int FRAC_DIGITS = 10
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 item_valid,
	input  dtfp_pkg::char_item_t item,
	output dtfp_pkg::fin_t       fin,
	output logic                 fin_valid
);
	import dtfp_pkg::*;

	localparam int IW4   = INT_BITS + 4;
	localparam int FW4   = FRAC_BITS + 4;
	localparam int PW    = $clog2(FRAC_DIGITS + 1);
	localparam int IDX_W = (FRAC_DIGITS > 1) ? $clog2(FRAC_DIGITS) : 1;

	logic [FRAC_BITS-1:0] weight_tab [FRAC_DIGITS];

	genvar k;
	generate
		for (k = 0; k < FRAC_DIGITS; k++) begin : g_weight
			localparam logic [63:0] WK =
				((64'd1 << FRAC_BITS) + TEN_POW[k] / 64'd2) / TEN_POW[k];
			assign weight_tab[k] = WK[FRAC_BITS-1:0];
		end
	endgenerate

	logic [INT_BITS-1:0]  int_q, int_n;
	logic [FRAC_BITS-1:0] frac_q, frac_n;
	logic                 int_seen_q, int_seen_n;
	logic [PW-1:0]        pos_q, pos_n;
	logic                 neg_q, neg_n;
	logic                 point_q, point_n;
	logic                 first_q, first_n;
	status_t              early_q, early_n;
	status_t              late_q, late_n;
	logic                 sat_q, sat_n;

	logic [7:0]           c;
	logic                 is_point, is_digit;
	logic [3:0]           d;
	logic [IW4-1:0]       int_mul;
	logic [FW4-1:0]       frac_sum;
	logic [FRAC_BITS-1:0] weight;
	status_t              status;
	logic [VALUE_W-1:0]   mag;

	fin_t                 fin_s2;
	logic                 fin_valid_s2;

	assign c        = item.char_code;
	assign is_point = (c == CHAR_DOT) || (c == CHAR_COMMA);
	assign is_digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
	assign d        = 4'(c - CHAR_ZERO);
	assign weight   = weight_tab[pos_q[IDX_W-1:0]];
	assign int_mul  = IW4'(int_q) * IW4'(TEN) + IW4'(d);
	assign frac_sum = FW4'(frac_q) + FW4'(d) * FW4'(weight);

	always_comb begin
		int_n      = int_q;
		frac_n     = frac_q;
		int_seen_n = int_seen_q;
		pos_n      = pos_q;
		neg_n      = neg_q;
		point_n    = point_q;
		first_n    = 1'b0;
		early_n    = early_q;
		late_n     = late_q;
		sat_n      = sat_q;
		if (early_q != ST_OK || c == CHAR_NUL) begin
			// skipped
		end else if (!point_q) begin
			if (first_q && c == CHAR_MINUS) begin
				neg_n = 1'b1;
			end else if (is_point) begin
				if (first_q) begin
					early_n = ST_EDGEPOINT;
				end else begin
					point_n = 1'b1;
				end
			end else if (!is_digit) begin
				early_n = ST_BADCHAR;
			end else begin
				int_seen_n = 1'b1;
				if (sat_q || int_mul[IW4-1:INT_BITS] != '0) begin
					int_n = '1;
					sat_n = 1'b1;
				end else begin
					int_n = int_mul[INT_BITS-1:0];
				end
			end
		end else begin
			if (is_point) begin
				late_n = int_seen_q ? ST_TWOPOINTS : ST_EDGEPOINT;
			end else if (!is_digit) begin
				late_n = ST_BADCHAR;
			end else if (pos_q < PW'(FRAC_DIGITS)) begin
				frac_n = (frac_sum[FW4-1:FRAC_BITS] != '0) ? '1 : frac_sum[FRAC_BITS-1:0];
				pos_n  = pos_q + 1'b1;
			end
		end
	end

	always_comb begin
		if (early_n != ST_OK) begin
			status = early_n;
		end else if (point_n && late_n != ST_OK) begin
			status = late_n;
		end else if (point_n && pos_n == '0) begin
			status = ST_EDGEPOINT;
		end else if (!int_seen_n && pos_n == '0) begin
			status = ST_EMPTY;
		end else if (!int_seen_n) begin
			status = ST_NOINT;
		end else if (sat_n) begin
			status = ST_OVERFLOW;
		end else begin
			status = ST_OK;
		end
	end

	assign mag = (status == ST_OK || status == ST_NOINT) ?
		((VALUE_W'(int_n) << FRAC_BITS) | VALUE_W'(frac_n)) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			int_q      <= '0;
			frac_q     <= '0;
			int_seen_q <= 1'b0;
			pos_q      <= '0;
			neg_q      <= 1'b0;
			point_q    <= 1'b0;
			first_q    <= 1'b1;
			early_q    <= ST_OK;
			late_q     <= ST_OK;
			sat_q      <= 1'b0;
		end else if (en && item_valid) begin
			if (item.last_char) begin
				int_q      <= '0;
				frac_q     <= '0;
				int_seen_q <= 1'b0;
				pos_q      <= '0;
				neg_q      <= 1'b0;
				point_q    <= 1'b0;
				first_q    <= 1'b1;
				early_q    <= ST_OK;
				late_q     <= ST_OK;
				sat_q      <= 1'b0;
			end else begin
				int_q      <= int_n;
				frac_q     <= frac_n;
				int_seen_q <= int_seen_n;
				pos_q      <= pos_n;
				neg_q      <= neg_n;
				point_q    <= point_n;
				first_q    <= first_n;
				early_q    <= early_n;
				late_q     <= late_n;
				sat_q      <= sat_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fin_valid_s2 <= 1'b0;
		end else if (en) begin
			fin_valid_s2 <= item_valid && item.last_char;
		end
	end

	always_ff @(posedge clk) begin
		if (en && item_valid && item.last_char) begin
			fin_s2.mag    <= mag;
			fin_s2.neg    <= neg_n;
			fin_s2.status <= status;
		end
	end

	assign fin       = fin_s2;
	assign fin_valid = fin_valid_s2;

endmodule

// ===== rtl/dtfp_out.sv =====
module dtfp_out (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  dtfp_pkg::fin_t    fin,
	input  logic              fin_valid,
	output dtfp_pkg::result_t res,
	output logic              res_valid
);
	import dtfp_pkg::*;

	result_t res_q;
	logic    res_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (en) begin
			res_valid_q <= fin_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en && fin_valid) begin
			res_q.value  <= fin.neg ? -$signed(fin.mag) : $signed(fin.mag);
			res_q.status <= fin.status;
		end
	end

	assign res       = res_q;
	assign res_valid = res_valid_q;

endmodule

// ===== rtl/decimal_text_to_fixed_point.sv =====
// Converts decimal text, one character per request, into a signed fixed-point
// number with INT_BITS integer and FRAC_BITS fraction bits (Q31.32 by default),
// right aligned and sign extended to 64 bits, plus a status code. One result
// follows the character flagged last_char. A leading '-' negates, '.' or ','
// is the decimal point, NUL characters are skipped, and fraction digits past
// FRAC_DIGITS are dropped. The value is zero unless the status is ok or no
// integer part. One character is taken every cycle unless chr_stall is high;
// a result passes the input register, character stage and output register,
// and the whole pipeline holds while a result waits on res_stall.
module decimal_text_to_fixed_point #(
	parameter int FRAC_BITS   = 32,
	parameter int INT_BITS    = 31,
	parameter int FRAC_DIGITS = 10
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  dtfp_pkg::char_item_t chr,
	input  logic                 chr_valid,
	output logic                 chr_stall,
	output dtfp_pkg::result_t    res,
	output logic                 res_valid,
	input  logic                 res_stall
);
	import dtfp_pkg::*;

	logic       en;
	char_item_t chr_s1;
	logic       chr_valid_s1;
	fin_t       fin;
	logic       fin_valid;

	assign en        = !(res_valid && res_stall);
	assign chr_stall = !en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chr_valid_s1 <= 1'b0;
		end else if (en) begin
			chr_valid_s1 <= chr_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en && chr_valid) begin
			chr_s1 <= chr;
		end
	end

	dtfp_step #(
		.FRAC_BITS  (FRAC_BITS),
		.INT_BITS   (INT_BITS),
		.FRAC_DIGITS(FRAC_DIGITS)
	) u_step (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.item_valid(chr_valid_s1),
		.item      (chr_s1),
		.fin       (fin),
		.fin_valid (fin_valid)
	);

	dtfp_out u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.fin      (fin),
		.fin_valid(fin_valid),
		.res      (res),
		.res_valid(res_valid)
	);

`ifndef SYNTHESIS
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.status != ST_OK && res.status != ST_NOINT |-> res.value == '0)
		else $error("nonzero value with error status");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		chr_stall |-> res_valid && res_stall)
		else $error("request stalled with no result waiting");

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.status == ST_OK && !res.value[VALUE_W-1]
		|-> (res.value >>> (INT_BITS + FRAC_BITS)) == '0)
		else $error("positive value beyond integer range");

	a_last_to_fin: assert property (@(posedge clk) disable iff (!arst_n)
		en && chr_valid_s1 && chr_s1.last_char |=> fin_valid)
		else $error("last character gave no finished number");
`endif

endmodule
